@@ hw/rtl/dvrt_pkg.sv @@
package dvrt_pkg;

  localparam int unsigned DVRT_DEPTH = 128;

  localparam logic [4:0] COST_INF    = 5'd16;
  localparam logic [7:0] TTL_DEFAULT = 8'd12;

  localparam int unsigned PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_TTL_ADDR = 2'd0;

  localparam logic [1:0] MODE_MERGE   = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_INSTALL = 2'd2;

  typedef enum logic [2:0] {
    ST_APPENDED   = 3'd0,
    ST_REPLACED   = 3'd1,
    ST_REFRESHED  = 3'd2,
    ST_IGNORED    = 3'd3,
    ST_FULL       = 3'd4,
    ST_LOCAL_DROP = 3'd5,
    ST_TICK       = 3'd6,
    ST_INSTALLED  = 3'd7
  } status_e;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] hop;
    logic [4:0]  metric;
    logic [7:0]  life;
  } entry_t;

endpackage

@@ hw/rtl/dvrt_if.sv @@
interface dvrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] destination;
  logic [31:0] next_hop;
  logic [31:0] sender_address;
  logic [4:0]  cost;

  modport source (output valid, mode, destination, next_hop, sender_address, cost,
                  input ready);
  modport sink   (input valid, mode, destination, next_hop, sender_address, cost,
                  output ready);
endinterface

interface dvrt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] entry_index;
  logic [7:0] route_total;

  modport source (output valid, status, entry_index, route_total, input ready);
  modport sink   (input valid, status, entry_index, route_total, output ready);
endinterface

@@ hw/rtl/distance_vector_route_table_core.sv @@
// distance-vector route table with a bounded number of entries
// req_i: valid/ready channel carrying one item (merge, aging tick or install);
//   a transaction is taken when valid and ready are both high, and ready is
//   high only while the sequencer is idle
// rsp_o: valid/ready channel with one result per item (status, entry index,
//   route total), held in an output register until the receiver takes it
// config: apb-style port, ttl_reload at byte address 0, pready always high
// steps per item: install writes the new entry and then loads the result
//   register, or loads the result alone when the table is full; tick reads
//   and rewrites each valid entry in turn; merge reads and compares entries
//   in the destination scan until a match or the last entry, then, when the
//   route is better, scans again for a local next hop, and writes an entry
//   when needed before loading the result; scans use the single table ram
//   read port with registered data, a read state before each compare or write
// a new item is accepted while the previous result still waits; a stalled
//   receiver holds the sequencer in its finish state until the output frees up
// reset clears the route count and the output valid, and sets ttl_reload to
//   12; table contents are not cleared, only entries below the count are read
module distance_vector_route_table_core import dvrt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DVRT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dvrt_in_if.sink            req_i,
  dvrt_out_if.source         rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] ttl_reload;

  dvrt_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .ttl_reload_o (ttl_reload)
  );

  dvrt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .ttl_reload_i (ttl_reload)
  );

endmodule

@@ hw/rtl/dvrt_cfg.sv @@
module dvrt_cfg import dvrt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [7:0]         ttl_reload_o
);

  logic [7:0] ttl_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_TTL_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TTL_DEFAULT;
    end else if (wr_en) begin
      ttl_q <= pwdata[7:0];
    end
  end

  assign prdata       = (paddr == REG_TTL_ADDR) ? {24'd0, ttl_q} : 32'd0;
  assign ttl_reload_o = ttl_q;

endmodule

@@ hw/rtl/dvrt_seq.sv @@
module dvrt_seq import dvrt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DVRT_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dvrt_in_if.sink    req_i,
  dvrt_out_if.source rsp_o,
  input  logic [7:0] ttl_reload_i
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CMP,
    S_LOCAL_RD,
    S_LOCAL_CMP,
    S_TICK_RD,
    S_TICK_WR,
    S_WRITE,
    S_FINISH
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] match_q;
  logic [IDX_W-1:0] widx_q;
  logic [IDX_W-1:0] res_slot_q;
  status_e          res_status_q;
  entry_t           went_q;
  logic [31:0]      dst_q;
  logic [31:0]      hop_q;
  logic [31:0]      sender_q;
  logic [4:0]       c_q;
  logic [4:0]       c1_q;

  entry_t           mem_q [TABLE_DEPTH];
  entry_t           rdata_q;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  logic [4:0]       c_sat;
  logic [4:0]       c_inc;
  logic [31:0]      cmp_key;
  logic             dest_eq;
  logic             full;
  logic             in_range;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] count_slot;
  entry_t           tick_e;
  entry_t           refresh_e;
  logic [IDX_W+6:0] slot_pad;
  logic [CNT_W+7:0] cnt_pad;

  assign c_sat = (req_i.cost > COST_INF) ? COST_INF : req_i.cost;
  assign c_inc = (c_sat == COST_INF) ? COST_INF : 5'(c_sat + 5'd1);

  // shared address compare: destination during the match scan, next hop otherwise
  assign cmp_key = (state_q == S_FIND_CMP) ? dst_q : hop_q;
  assign dest_eq = (rdata_q.dest == cmp_key);

  assign full       = (count_q == DEPTH_C);
  assign in_range   = (idx_q < count_q);
  assign cur_idx    = idx_q[IDX_W-1:0];
  assign count_slot = count_q[IDX_W-1:0];

  always_comb begin
    tick_e = rdata_q;
    if (rdata_q.life != 8'd0) begin
      tick_e.life = 8'(rdata_q.life - 8'd1);
    end else begin
      tick_e.metric = COST_INF;
    end
    refresh_e      = rdata_q;
    refresh_e.life = ttl_reload_i;
  end

  assign mem_we    = (state_q == S_WRITE) || (state_q == S_TICK_WR);
  assign mem_waddr = (state_q == S_TICK_WR) ? cur_idx : widx_q;
  assign mem_wdata = (state_q == S_TICK_WR) ? tick_e : went_q;
  assign mem_raddr = cur_idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign slot_pad    = (IDX_W + 7)'(res_slot_q);
  assign cnt_pad     = (CNT_W + 8)'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      idx_q             <= '0;
      count_q           <= '0;
      match_q           <= '0;
      widx_q            <= '0;
      res_slot_q        <= '0;
      res_status_q      <= ST_IGNORED;
      went_q            <= '0;
      dst_q             <= '0;
      hop_q             <= '0;
      sender_q          <= '0;
      c_q               <= '0;
      c1_q              <= '0;
      rsp_o.valid       <= 1'b0;
      rsp_o.status      <= '0;
      rsp_o.entry_index <= '0;
      rsp_o.route_total <= '0;
    end else begin
      if (rsp_o.valid && rsp_o.ready && (state_q != S_FINISH)) begin
        rsp_o.valid <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            dst_q      <= req_i.destination;
            hop_q      <= req_i.next_hop;
            sender_q   <= req_i.sender_address;
            c_q        <= c_sat;
            c1_q       <= c_inc;
            idx_q      <= '0;
            res_slot_q <= '0;
            case (req_i.mode)
              MODE_MERGE: state_q <= S_FIND_RD;
              MODE_TICK:  state_q <= S_TICK_RD;
              MODE_INSTALL: begin
                if (full) begin
                  res_status_q <= ST_FULL;
                  state_q      <= S_FINISH;
                end else begin
                  went_q       <= '{req_i.destination, req_i.next_hop, c_sat, ttl_reload_i};
                  widx_q       <= count_slot;
                  res_slot_q   <= count_slot;
                  count_q      <= count_q + 1'b1;
                  res_status_q <= ST_INSTALLED;
                  state_q      <= S_WRITE;
                end
              end
              default: begin
                res_status_q <= ST_IGNORED;
                state_q      <= S_FINISH;
              end
            endcase
          end
        end
        S_FIND_RD: begin
          if (in_range) begin
            state_q <= S_FIND_CMP;
          end else if (full) begin
            res_status_q <= ST_FULL;
            state_q      <= S_FINISH;
          end else begin
            went_q       <= '{dst_q, hop_q, c1_q, ttl_reload_i};
            widx_q       <= count_slot;
            res_slot_q   <= count_slot;
            count_q      <= count_q + 1'b1;
            res_status_q <= ST_APPENDED;
            state_q      <= S_WRITE;
          end
        end
        S_FIND_CMP: begin
          if (dest_eq) begin
            match_q <= cur_idx;
            if (rdata_q.metric == 5'd0) begin
              went_q       <= refresh_e;
              widx_q       <= cur_idx;
              res_slot_q   <= cur_idx;
              res_status_q <= ST_REFRESHED;
              state_q      <= S_WRITE;
            end else if (c1_q < rdata_q.metric) begin
              idx_q   <= '0;
              state_q <= S_LOCAL_RD;
            end else if (hop_q == sender_q) begin
              if (c_q == COST_INF) begin
                went_q       <= '{dst_q, hop_q, COST_INF, ttl_reload_i};
                widx_q       <= cur_idx;
                res_slot_q   <= cur_idx;
                res_status_q <= ST_REPLACED;
                state_q      <= S_WRITE;
              end else begin
                res_status_q <= ST_IGNORED;
                state_q      <= S_FINISH;
              end
            end else if (hop_q == rdata_q.hop) begin
              went_q       <= refresh_e;
              widx_q       <= cur_idx;
              res_slot_q   <= cur_idx;
              res_status_q <= ST_REFRESHED;
              state_q      <= S_WRITE;
            end else begin
              res_status_q <= ST_IGNORED;
              state_q      <= S_FINISH;
            end
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_FIND_RD;
          end
        end
        S_LOCAL_RD: begin
          if (in_range) begin
            state_q <= S_LOCAL_CMP;
          end else begin
            went_q       <= '{dst_q, hop_q, c1_q, ttl_reload_i};
            widx_q       <= match_q;
            res_slot_q   <= match_q;
            res_status_q <= ST_REPLACED;
            state_q      <= S_WRITE;
          end
        end
        S_LOCAL_CMP: begin
          if ((rdata_q.metric == 5'd0) && dest_eq) begin
            res_status_q <= ST_LOCAL_DROP;
            state_q      <= S_FINISH;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_LOCAL_RD;
          end
        end
        S_TICK_RD: begin
          if (in_range) begin
            state_q <= S_TICK_WR;
          end else begin
            res_status_q <= ST_TICK;
            state_q      <= S_FINISH;
          end
        end
        S_TICK_WR: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= S_TICK_RD;
        end
        S_WRITE: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp_o.valid || rsp_o.ready) begin
            rsp_o.valid       <= 1'b1;
            rsp_o.status      <= res_status_q;
            rsp_o.entry_index <= slot_pad[6:0];
            rsp_o.route_total <= cnt_pad[7:0];
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/tb_distance_vector_route_table_core.sv @@
`timescale 1ns / 100ps

module tb_distance_vector_route_table_core;
  import dvrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned POOL_SIZE = 40;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] dst;
    logic [31:0] hop;
    logic [31:0] snd;
    logic [4:0]  cost;
  } route_item_t;

  typedef struct packed {
    status_e    status;
    logic [6:0] idx;
    logic [7:0] total;
  } route_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  dvrt_in_if  req_if();
  dvrt_out_if rsp_if();

  distance_vector_route_table_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the route table
  entry_t      tbl [DVRT_DEPTH];
  int unsigned tbl_count = 0;
  logic [7:0]  ttl_shadow = TTL_DEFAULT;

  route_item_t route_item_q[$];
  route_rsp_t  route_rsp_q[$];
  route_item_t drv_item;
  route_rsp_t  exp_rsp;
  logic [31:0] addr_pool [POOL_SIZE];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic route_rsp_t predict_route(route_item_t it);
    route_rsp_t  r;
    logic [4:0]  c;
    logic [4:0]  c1;
    int unsigned slot;
    int unsigned hit;
    int unsigned j;
    bit          found;
    bit          local_hop;
    r.status = ST_IGNORED;
    slot = 0;
    c = (it.cost > COST_INF) ? COST_INF : it.cost;
    c1 = (c >= COST_INF) ? COST_INF : c + 5'd1;
    case (it.mode)
      MODE_TICK: begin
        for (j = 0; j < tbl_count; j++) begin
          if (tbl[j].life != 8'd0) tbl[j].life = tbl[j].life - 8'd1;
          else tbl[j].metric = COST_INF;
        end
        r.status = ST_TICK;
      end
      MODE_INSTALL: begin
        if (tbl_count < DVRT_DEPTH) begin
          slot = tbl_count;
          tbl[slot] = '{dest: it.dst, hop: it.hop, metric: c, life: ttl_shadow};
          tbl_count++;
          r.status = ST_INSTALLED;
        end else begin
          r.status = ST_FULL;
        end
      end
      MODE_MERGE: begin
        found = 1'b0;
        hit = 0;
        for (j = 0; j < tbl_count && !found; j++) begin
          if (tbl[j].dest == it.dst) begin
            found = 1'b1;
            hit = j;
          end
        end
        if (found) begin
          if (tbl[hit].metric == 5'd0) begin
            tbl[hit].life = ttl_shadow;
            r.status = ST_REFRESHED;
            slot = hit;
          end else if (c1 < tbl[hit].metric) begin
            local_hop = 1'b0;
            for (j = 0; j < tbl_count; j++) begin
              if (tbl[j].metric == 5'd0 && tbl[j].dest == it.hop) local_hop = 1'b1;
            end
            if (local_hop) begin
              r.status = ST_LOCAL_DROP;
            end else begin
              tbl[hit] = '{dest: it.dst, hop: it.hop, metric: c1, life: ttl_shadow};
              r.status = ST_REPLACED;
              slot = hit;
            end
          end else if (it.hop == it.snd) begin
            if (c == COST_INF) begin
              tbl[hit] = '{dest: it.dst, hop: it.hop, metric: COST_INF, life: ttl_shadow};
              r.status = ST_REPLACED;
              slot = hit;
            end
          end else if (it.hop == tbl[hit].hop) begin
            tbl[hit].life = ttl_shadow;
            r.status = ST_REFRESHED;
            slot = hit;
          end
        end else if (tbl_count < DVRT_DEPTH) begin
          slot = tbl_count;
          tbl[slot] = '{dest: it.dst, hop: it.hop, metric: c1, life: ttl_shadow};
          tbl_count++;
          r.status = ST_APPENDED;
        end else begin
          r.status = ST_FULL;
        end
      end
      default: ;
    endcase
    r.idx = slot[6:0];
    r.total = tbl_count[7:0];
    return r;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.mode <= MODE_MERGE;
      req_if.destination <= '0;
      req_if.next_hop <= '0;
      req_if.sender_address <= '0;
      req_if.cost <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        route_rsp_q.push_back(predict_route(drv_item));
      end
      if (!req_if.valid || req_if.ready) begin
        if (route_item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_item = route_item_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.mode <= drv_item.mode;
          req_if.destination <= drv_item.dst;
          req_if.next_hop <= drv_item.hop;
          req_if.sender_address <= drv_item.snd;
          req_if.cost <= drv_item.cost;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (route_rsp_q.size() == 0) begin
          $display("%0t: unexpected transaction: status %0d, index %0d, total %0d",
                   $time, rsp_if.status, rsp_if.entry_index, rsp_if.route_total);
          err_cnt++;
        end else begin
          exp_rsp = route_rsp_q.pop_front();
          if (rsp_if.status !== exp_rsp.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_rsp.status, rsp_if.status);
            err_cnt++;
          end
          if (rsp_if.entry_index !== exp_rsp.idx) begin
            $display("%0t: entry_index mismatch: expected %0d, actual %0d",
                     $time, exp_rsp.idx, rsp_if.entry_index);
            err_cnt++;
          end
          if (rsp_if.route_total !== exp_rsp.total) begin
            $display("%0t: route_total mismatch: expected %0d, actual %0d",
                     $time, exp_rsp.total, rsp_if.route_total);
            err_cnt++;
          end
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] mode, input logic [31:0] dst,
                            input logic [31:0] hop, input logic [31:0] snd,
                            input logic [4:0] cost);
    while (route_item_q.size() > 2) @(negedge clk_i);
    route_item_q.push_back('{mode: mode, dst: dst, hop: hop, snd: snd, cost: cost});
  endtask

  task automatic wait_idle();
    while (route_item_q.size() != 0 || req_if.valid || route_rsp_q.size() != 0)
      @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic set_ttl(input logic [7:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_TTL_ADDR;
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    ttl_shadow = value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[7:0] !== value) begin
      $display("%0t: ttl_reload readback mismatch: expected %0d, actual %0d",
               $time, value, prdata[7:0]);
      err_cnt++;
    end
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [4:0] pick_cost();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 4) return 5'd0;
    if (r < 8) return COST_INF;
    if (r == 19) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(0, 16));
  endfunction

  task automatic queue_random_item();
    int unsigned r;
    int unsigned k;
    logic [31:0] dst;
    logic [31:0] hop;
    logic [31:0] snd;
    r = $urandom_range(0, 99);
    dst = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    hop = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    snd = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 62) begin
      k = $urandom_range(0, 99);
      if (tbl_count != 0 && k < 40) begin
        dst = tbl[$urandom_range(0, tbl_count - 1)].dest;
        if ($urandom_range(0, 1)) hop = tbl[$urandom_range(0, tbl_count - 1)].hop;
      end else if (k < 50) begin
        dst = $urandom;
      end
      if (tbl_count != 0 && $urandom_range(0, 3) == 0)
        hop = tbl[$urandom_range(0, tbl_count - 1)].dest;
      if ($urandom_range(0, 9) < 4) snd = hop;
      queue_item(MODE_MERGE, dst, hop, snd, pick_cost());
    end else if (r < 80) begin
      queue_item(MODE_TICK, $urandom, $urandom, $urandom, 5'($urandom_range(0, 31)));
    end else begin
      queue_item(MODE_INSTALL, dst, hop, snd, pick_cost());
    end
  endtask

  initial begin
    int unsigned ph;
    req_if.valid = 1'b0;
    req_if.mode = MODE_MERGE;
    req_if.destination = '0;
    req_if.next_hop = '0;
    req_if.sender_address = '0;
    req_if.cost = '0;
    rsp_if.ready = 1'b0;
    rst_ni = 1'b0;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = 32'h5555_5555;
    addr_pool[3] = 32'hAAAA_AAAA;
    for (int i = 4; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_ttl(TTL_DEFAULT);

    // directed: every status but full, saturation, local routes, poison, mode 3
    queue_item(MODE_TICK, 32'h0, 32'h0, 32'h0, 5'd0);
    queue_item(MODE_MERGE, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0);
    queue_item(MODE_INSTALL, 32'h0A00_0001, 32'h0000_0000, 32'h0, 5'd0);
    queue_item(MODE_MERGE, 32'h0A00_0001, 32'hC0A8_0001, 32'h0102_0304, 5'd5);
    queue_item(MODE_INSTALL, 32'hFFFF_FFFF, 32'h5555_5555, 32'h0, 5'd10);
    queue_item(MODE_MERGE, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0102_0304, 5'd3);
    queue_item(MODE_MERGE, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0102_0304, 5'd3);
    queue_item(MODE_MERGE, 32'hFFFF_FFFF, 32'h0102_0304, 32'h0102_0304, COST_INF);
    queue_item(MODE_MERGE, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'hAAAA_AAAA, 5'd5);
    queue_item(MODE_MERGE, 32'hFFFF_FFFF, 32'h0102_0304, 32'h0102_0304, 5'd8);
    queue_item(MODE_MERGE, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0102_0304, 5'd9);
    queue_item(MODE_MERGE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 5'd9);
    queue_item(MODE_MERGE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 5'd31);
    queue_item(MODE_INSTALL, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 5'd20);
    queue_item(MODE_MERGE, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd15);
    queue_item(MODE_MERGE, 32'h5555_5555, 32'h0000_0001, 32'h0000_0002, 5'd14);
    queue_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    queue_item(MODE_MERGE, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, COST_INF);
    repeat (3) queue_item(MODE_TICK, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 5'd16);
    queue_item(MODE_INSTALL, 32'h0000_0000, 32'h0000_0000, 32'h0, COST_INF);
    wait_idle();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          set_ttl(8'd255);
        end
        1: begin
          send_idle_pct = 78;
          recv_stall_pct = 0;
          set_ttl(8'd1);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 78;
          set_ttl(8'($urandom_range(2, 254)));
        end
        default: begin
          send_idle_pct = 12;
          recv_stall_pct = 12;
          set_ttl(8'd0);
        end
      endcase
      repeat (170) queue_random_item();
      if (ph == 3) begin
        while (tbl_count < DVRT_DEPTH)
          queue_item(MODE_INSTALL, $urandom, $urandom, $urandom, pick_cost());
        repeat (60) queue_random_item();
      end
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/dvrt_pkg.sv
hw/rtl/dvrt_if.sv
hw/rtl/dvrt_cfg.sv
hw/rtl/dvrt_seq.sv
hw/rtl/distance_vector_route_table_core.sv
tb/tb_distance_vector_route_table_core.sv
